// File: src/b64d_pkg.sv
package b64d_pkg;

    localparam int unsigned POSITION_BITS_DEFAULT = 16;
    localparam int unsigned POS_OUT_BITS = 16;
    localparam int unsigned GROUP_SIZE = 4;
    localparam logic [1:0] LAST_PHASE = 2'(GROUP_SIZE - 1);
    localparam logic [1:0] PAD_PHASE = 2'(GROUP_SIZE - 2);
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [6:0] SEXTET_NONE = 7'd64;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_CHAR = 2'd1,
        STAT_BAD_LEN  = 2'd2
    } status_t;

    // results released by one character: data bytes first, then an optional status
    typedef struct packed {
        logic [2:0][7:0]         bytes;
        logic [1:0]              nbytes;
        logic                    has_status;
        status_t                 code;
        logic [POS_OUT_BITS-1:0] pos;
    } res_grp_t;

    // rfc 4648 alphabet, SEXTET_NONE for anything else
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = SEXTET_NONE;
        priority if (c >= 8'h41 && c <= 8'h5A)
            v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            v = 7'd62;
        else if (c == 8'h2F)
            v = 7'd63;
        else
            v = SEXTET_NONE;
        return v;
    endfunction

endpackage

// File: src/b64d_step.sv
module b64d_step #(
    parameter int unsigned POSITION_BITS = b64d_pkg::POSITION_BITS_DEFAULT
) (
    input  logic [7:0]               char_in,
    input  logic                     last_char,
    input  logic [1:0]               phase,
    input  logic [17:0]              held,
    input  logic [POSITION_BITS-1:0] count,
    input  logic                     err_seen,
    input  logic [POSITION_BITS-1:0] err_index,
    input  logic                     pad_pend,
    output logic [1:0]               phase_next,
    output logic [17:0]              held_next,
    output logic [POSITION_BITS-1:0] count_next,
    output logic                     err_seen_next,
    output logic [POSITION_BITS-1:0] err_index_next,
    output logic                     pad_pend_next,
    output b64d_pkg::res_grp_t       grp
);
    import b64d_pkg::*;

    localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

    logic [6:0]               sext;
    logic                     is_pad;
    logic [23:0]              word;
    logic [2:0][7:0]          bytes;
    logic [1:0]               nbytes;
    logic                     e_seen;
    logic [POSITION_BITS-1:0] e_idx;
    logic                     p_pend;
    logic [17:0]              h_new;
    logic [POSITION_BITS-1:0] cnt_inc;

    always_comb
    begin
        sext   = sextet_of(char_in);
        is_pad = (char_in == PAD_CHAR);
        word   = {held, sext[5:0]};
        bytes  = '0;
        nbytes = 2'd0;
        e_seen = err_seen;
        e_idx  = err_index;
        p_pend = pad_pend;
        h_new  = held;

        if (!err_seen)
        begin
            if (pad_pend)
            begin
                // third place was '=', fourth must be a final '='
                if (is_pad && last_char)
                begin
                    bytes[0] = {held[11:6], held[5:4]};
                    nbytes   = 2'd1;
                end
                else
                begin
                    e_seen = 1'b1;
                end
                p_pend = 1'b0;
            end
            else if (sext != SEXTET_NONE)
            begin
                if (phase == LAST_PHASE)
                begin
                    bytes[0] = word[23:16];
                    bytes[1] = word[15:8];
                    bytes[2] = word[7:0];
                    nbytes   = 2'd3;
                end
                h_new = word[17:0];
            end
            else if (is_pad && phase == PAD_PHASE && !last_char)
            begin
                p_pend = 1'b1;
                e_idx  = count;
            end
            else if (is_pad && phase == LAST_PHASE && last_char)
            begin
                bytes[0] = held[17:10];
                bytes[1] = held[9:2];
                nbytes   = 2'd2;
            end
            else
            begin
                e_seen = 1'b1;
                e_idx  = count;
            end
        end

        cnt_inc = (count < COUNT_MAX) ? count + 1'b1 : count;

        grp            = '0;
        grp.bytes      = bytes;
        grp.nbytes     = nbytes;
        grp.has_status = 1'b0;
        grp.code       = STAT_OK;
        grp.pos        = '0;

        if (last_char)
        begin
            if (phase != LAST_PHASE)
            begin
                grp.nbytes     = 2'd0;
                grp.has_status = 1'b1;
                grp.code       = STAT_BAD_LEN;
                grp.pos        = POS_OUT_BITS'(cnt_inc);
            end
            else if (e_seen)
            begin
                grp.nbytes     = 2'd0;
                grp.has_status = 1'b1;
                grp.code       = STAT_BAD_CHAR;
                grp.pos        = POS_OUT_BITS'(e_idx);
            end
            else
            begin
                grp.has_status = 1'b1;
            end
            // string done, back to the reset state
            phase_next     = 2'd0;
            held_next      = '0;
            count_next     = '0;
            err_seen_next  = 1'b0;
            err_index_next = '0;
            pad_pend_next  = 1'b0;
        end
        else
        begin
            phase_next     = phase + 2'd1;
            held_next      = h_new;
            count_next     = cnt_inc;
            err_seen_next  = e_seen;
            err_index_next = e_idx;
            pad_pend_next  = p_pend;
        end
    end

endmodule

// File: src/base64_stream_decoder_unit.sv
// path: an accepted character request is registered in char_reg, then decoded into
//   grp_reg once the group frees up, and its results are offered from there
// throughput: one character request per cycle while each yields at most one result and no
//   out_stall holds it; the result port moves one result per cycle, so a full group of 3
//   bytes (4 at the end of a string) holds the decode stage until its last one leaves
// reset: asynchronous active-low rst_n clears the decode state and both stage valids
module base64_stream_decoder_unit #(
    parameter int unsigned POSITION_BITS = b64d_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // character requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        char_in,
    input  logic                              last_char,
    // result requests
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        data_byte,
    output logic                              is_status,
    output logic [1:0]                        status_code,
    output logic [b64d_pkg::POS_OUT_BITS-1:0] position,
    output logic                              last_result
);
    import b64d_pkg::*;

    // input register: holds one character so a new request can land while
    // the result group is still draining
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] char_reg;
    logic       last_reg;

    // decoder state, advanced when a character moves into the result group
    logic [1:0]               phase_reg,   phase_next;
    logic [17:0]              held_reg,    held_next;
    logic [POSITION_BITS-1:0] count_reg,   count_next;
    logic                     err_reg,     err_next;
    logic [POSITION_BITS-1:0] err_idx_reg, err_idx_next;
    logic                     pad_reg,     pad_next;

    // result group register and its read pointer
    res_grp_t   grp_reg;
    res_grp_t   grp_new;
    logic [2:0] total_reg;
    logic [2:0] total_new;
    logic [2:0] ptr_reg;
    logic [2:0] ptr_next;

    logic in_accept;
    logic out_accept;
    logic grp_free;
    logic move;

    b64d_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .char_in        (char_reg),
        .last_char      (last_reg),
        .phase          (phase_reg),
        .held           (held_reg),
        .count          (count_reg),
        .err_seen       (err_reg),
        .err_index      (err_idx_reg),
        .pad_pend       (pad_reg),
        .phase_next     (phase_next),
        .held_next      (held_next),
        .count_next     (count_next),
        .err_seen_next  (err_next),
        .err_index_next (err_idx_next),
        .pad_pend_next  (pad_next),
        .grp            (grp_new)
    );

    assign total_new = {1'b0, grp_new.nbytes} + {2'b0, grp_new.has_status};

    // output side: data bytes in order, then the status item if any
    assign out_valid  = (ptr_reg < total_reg);
    assign out_accept = out_valid && !out_stall;

    always_comb
    begin
        if ({1'b0, ptr_reg[1:0]} < {1'b0, grp_reg.nbytes} && ptr_reg < 3'd3)
        begin
            data_byte   = grp_reg.bytes[ptr_reg[1:0]];
            is_status   = 1'b0;
            status_code = STAT_OK;
            position    = '0;
            last_result = 1'b0;
        end
        else
        begin
            data_byte   = '0;
            is_status   = 1'b1;
            status_code = grp_reg.code;
            position    = grp_reg.pos;
            last_result = 1'b1;
        end
    end

    // the group frees up when it is empty or its final result leaves this cycle
    assign grp_free = !out_valid || ((ptr_reg + 3'd1 == total_reg) && out_accept);
    assign move     = in_vld_reg && grp_free;

    assign in_stall    = in_vld_reg && !move;
    assign in_accept   = in_valid && !in_stall;
    assign in_vld_next = in_accept || (in_vld_reg && !move);

    always_comb
    begin
        if (move)
            ptr_next = 3'd0;
        else if (out_accept)
            ptr_next = ptr_reg + 3'd1;
        else
            ptr_next = ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            ptr_reg     <= 3'd0;
            total_reg   <= 3'd0;
            phase_reg   <= 2'd0;
            held_reg    <= '0;
            count_reg   <= '0;
            err_reg     <= 1'b0;
            err_idx_reg <= '0;
            pad_reg     <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            ptr_reg    <= ptr_next;
            if (move)
            begin
                total_reg   <= total_new;
                phase_reg   <= phase_next;
                held_reg    <= held_next;
                count_reg   <= count_next;
                err_reg     <= err_next;
                err_idx_reg <= err_idx_next;
                pad_reg     <= pad_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_reg <= char_in;
            last_reg <= last_char;
        end
        if (move)
            grp_reg <= grp_new;
    end

endmodule
